[hw/rtl/rgb_ramp_bounce_generator_unit_macros.svh]
// Assertion macros for the RGB ramp and bounce generator.
`ifndef RGB_RAMP_BOUNCE_GENERATOR_UNIT_MACROS_SVH
`define RGB_RAMP_BOUNCE_GENERATOR_UNIT_MACROS_SVH

// Implication in the same cycle, disabled while reset is held.
`define RRB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrb assertion failed");

// Implication into the next cycle, checked through reset as well.
`define RRB_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rrb assertion failed");

`endif

[hw/rtl/rrb_pkg.sv]
// Shared types and constants for the RGB ramp and bounce generator.
`default_nettype none
package rrb_pkg;

    localparam int LEVEL_W   = 8;
    localparam int STEP_W    = 7;
    localparam int MASK_W    = 3;
    localparam int MODE_W    = 3;
    localparam int CHANNELS  = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W:0]   REFLECT_TOP = 9'd510;

    localparam int MASK_LSB = 0;
    localparam int MODE_LSB = MASK_LSB + MASK_W;
    localparam int STEP_LSB = MODE_LSB + MODE_W;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [STEP_W-1:0]  step_t;

    // mode field, bit0 rising, bit1 wrap, bit2 bounce
    typedef struct packed {
        logic bounce;
        logic wrap;
        logic rising;
    } mode_t;

endpackage
`default_nettype wire

[hw/rtl/rrb_channel.sv]
// Per-channel wrap and bounce move for one tick.
`default_nettype none
module rrb_channel (
    input  wire logic           en,
    input  wire rrb_pkg::mode_t mode,
    input  wire rrb_pkg::step_t step_size,
    input  wire rrb_pkg::level_t level_in,
    input  wire logic           dir_in,
    output rrb_pkg::level_t     level_next,
    output logic                dir_next
);
    import rrb_pkg::*;

    level_t           wrapped;
    logic [LEVEL_W:0] up_sum;
    logic [LEVEL_W:0] down_diff;
    level_t           bounced;
    logic             bounce_dir;

    always_comb begin
        wrapped = level_in;
        if (mode.wrap) begin
            if (mode.rising) begin
                wrapped = level_in + LEVEL_W'(step_size);
            end else begin
                wrapped = level_in - LEVEL_W'(step_size);
            end
        end

        up_sum    = {1'b0, wrapped} + (LEVEL_W+1)'(step_size);
        down_diff = {1'b0, wrapped} - (LEVEL_W+1)'(step_size);
        bounced    = wrapped;
        bounce_dir = dir_in;
        if (dir_in) begin
            if (up_sum > {1'b0, LEVEL_MAX}) begin
                bounced    = LEVEL_W'(REFLECT_TOP - up_sum);
                bounce_dir = 1'b0;
            end else begin
                bounced = up_sum[LEVEL_W-1:0];
            end
        end else begin
            if (down_diff[LEVEL_W]) begin
                bounced    = LEVEL_W'(step_size) - wrapped;
                bounce_dir = 1'b1;
            end else begin
                bounced = down_diff[LEVEL_W-1:0];
            end
        end

        level_next = level_in;
        dir_next   = dir_in;
        if (en) begin
            level_next = mode.bounce ? bounced : wrapped;
            dir_next   = mode.bounce ? bounce_dir : dir_in;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rgb_ramp_bounce_generator_unit.sv]
// Top level of the RGB ramp and bounce generator.
//
//  channel | dir | tdata fields (low bit up)
//  s_      | in  | channel_mask[2:0] mode[5:3] step_size[12:6], zero fill to 16
//  m_      | out | red_out[7:0] green_out[15:8] blue_out[23:16]
//
// One tick per cycle sustained while m_ accepts every word.
// Input register, then combinational channel logic into the colour registers.
// The colour registers are the output register; they only move when it is empty or drains.
// Reset clears levels and directions to zero, all channels falling.
// A stalled m_ side holds the input register and then drops s_tready.
`default_nettype none
module rgb_ramp_bounce_generator_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // channel_mask[2:0], mode[5:3], step_size[12:6], zero fill [15:13]
    input  wire logic [rrb_pkg::S_DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [rrb_pkg::M_DATA_W-1:0]      m_tdata
);
    import rrb_pkg::*;

    logic                in_valid_reg;
    logic [MASK_W-1:0]   mask_reg;
    mode_t               mode_reg;
    step_t               step_reg;
    logic                m_valid_reg;
    level_t              level_reg  [CHANNELS];
    level_t              level_next [CHANNELS];
    logic [CHANNELS-1:0] dir_reg;
    logic [CHANNELS-1:0] dir_next;
    logic                advance;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {level_reg[2], level_reg[1], level_reg[0]};

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
        rrb_channel u_channel (
            .en         (mask_reg[ch]),
            .mode       (mode_reg),
            .step_size  (step_reg),
            .level_in   (level_reg[ch]),
            .dir_in     (dir_reg[ch]),
            .level_next (level_next[ch]),
            .dir_next   (dir_next[ch])
        );
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mask_reg <= s_tdata[MASK_LSB +: MASK_W];
            mode_reg <= s_tdata[MODE_LSB +: MODE_W];
            step_reg <= s_tdata[STEP_LSB +: STEP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            dir_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    dir_reg <= dir_next;
                    for (int i = 0; i < CHANNELS; i++) begin
                        level_reg[i] <= level_next[i];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rrb_checker.sv]
// Port-level checker for the RGB ramp and bounce generator, with its bind.
`default_nettype none
`include "rgb_ramp_bounce_generator_unit_macros.svh"
module rrb_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [rrb_pkg::M_DATA_W-1:0] m_tdata
);
    import rrb_pkg::*;

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    `RRB_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)
    `RRB_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `RRB_ASSERT_IMP(a_word_emerges, aclk, aresetn, s_fire, ##2 m_tvalid)
    `RRB_ASSERT_IMP(a_stall_holds, aclk, aresetn, m_stall, ##1 (m_tvalid && $stable(m_tdata)))

endmodule

bind rgb_ramp_bounce_generator_unit rrb_checker u_rrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
